// ----- sv/blob_cluster_accumulator_assert.svh -----
// Assertion macros for the blob cluster accumulator checker.
// Depends on nothing; included by the checker file.
`ifndef BLOB_CLUSTER_ACCUMULATOR_ASSERT_SVH
`define BLOB_CLUSTER_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define BCA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bca assertion failed");

// Next-cycle implication, disabled while reset is active.
`define BCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bca assertion failed");

`endif

// ----- sv/bca_pkg.sv -----
// Shared types, constants and codes for the blob cluster accumulator.
// Depends on nothing; imported by every module of the block.
package bca_pkg;

  localparam int SLOTS      = 128;
  localparam int COORD_BITS = 11;
  localparam int FRAC_BITS  = 8;
  localparam int COUNT_BITS = 16;

  localparam int MEAN_BITS  = COORD_BITS + FRAC_BITS;
  localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SIU_BITS   = 8;
  localparam int RADIUS_BITS = 11;
  localparam int SCAN_BITS  = (SLOT_BITS + 1 > SIU_BITS) ? SLOT_BITS + 1 : SIU_BITS;

  localparam int SLOT_IDX_BITS = 7;
  localparam int OUT_MEAN_BITS = 19;
  localparam int OUT_CNT_BITS  = 16;

  localparam int DIVIDEND_BITS = MEAN_BITS + COUNT_BITS + 1;
  localparam int DIVISOR_BITS  = COUNT_BITS + 1;
  localparam int DIV_STEPS     = DIVIDEND_BITS;
  localparam int STEP_BITS     = $clog2(DIV_STEPS);

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 11;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_RADIUS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SLOTS_IN_USE = 1'd1;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET       = 11'd50;
  localparam logic [SIU_BITS-1:0]    SLOTS_IN_USE_RESET = 8'd99;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    OUT_NEW  = 2'd0,
    OUT_JOIN = 2'd1,
    OUT_DROP = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_row;
    logic [COORD_BITS-1:0] pixel_col;
  } pixel_t;

  typedef struct packed {
    outcome_e                   outcome;
    logic [SLOT_IDX_BITS-1:0]   slot_index;
    logic [OUT_MEAN_BITS-1:0]   mean_row;
    logic [OUT_MEAN_BITS-1:0]   mean_col;
    logic [OUT_CNT_BITS-1:0]    member_count;
  } result_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [MEAN_BITS-1:0]  row_mean;
    logic [MEAN_BITS-1:0]  col_mean;
  } slot_entry_t;

  typedef struct packed {
    logic [DIVIDEND_BITS-1:0] dividend_row;
    logic [DIVIDEND_BITS-1:0] dividend_col;
    logic [DIVISOR_BITS-1:0]  divisor;
  } div_req_t;

endpackage

// ----- sv/bca_divider.sv -----
// Two-lane restoring divider, one quotient bit per lane per cycle.
// Depends on bca_pkg; used by blob_cluster_accumulator for the running means.
module bca_divider import bca_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  div_req_t             req_i,
  output logic                 done_o,
  output logic [MEAN_BITS-1:0] quot_row_o,
  output logic [MEAN_BITS-1:0] quot_col_o
);

  function automatic logic [DIVISOR_BITS+DIVIDEND_BITS-1:0] div_step(
    input logic [DIVISOR_BITS-1:0]  rem,
    input logic [DIVIDEND_BITS-1:0] dq,
    input logic [DIVISOR_BITS-1:0]  dvs
  );
    logic [DIVISOR_BITS:0] trial;
    logic [DIVISOR_BITS:0] diff;
    logic                  ge;
    trial = {rem, dq[DIVIDEND_BITS-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
    div_step = {(ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0]),
                dq[DIVIDEND_BITS-2:0], ge};
  endfunction

  logic [DIVISOR_BITS-1:0]  rem_row_q, rem_col_q, dvs_q;
  logic [DIVIDEND_BITS-1:0] dq_row_q, dq_col_q;
  logic [STEP_BITS-1:0]     step_q;
  logic                     run_q, done_q;
  logic                     last_step;

  assign last_step = (step_q == STEP_BITS'(DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (run_q) begin
      run_q  <= !last_step;
      done_q <= last_step;
      step_q <= step_q + STEP_BITS'(1);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_row_q <= '0;
      rem_col_q <= '0;
      dq_row_q  <= req_i.dividend_row;
      dq_col_q  <= req_i.dividend_col;
      dvs_q     <= req_i.divisor;
    end else if (run_q) begin
      {rem_row_q, dq_row_q} <= div_step(rem_row_q, dq_row_q, dvs_q);
      {rem_col_q, dq_col_q} <= div_step(rem_col_q, dq_col_q, dvs_q);
    end
  end

  assign done_o     = done_q;
  assign quot_row_o = dq_row_q[MEAN_BITS-1:0];
  assign quot_col_o = dq_col_q[MEAN_BITS-1:0];

endmodule

// ----- sv/blob_cluster_accumulator.sv -----
// Top level of the blob cluster accumulator: slot memory, scan FSM, config.
// Depends on bca_pkg and bca_divider.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------
//   input     | start_i, busy_o      | pixel_i (pixel_t)
//   result    | valid_o (one cycle)  | result_o (result_t)
//   config    | cfg_we_i, cfg_idx_i  | cfg_wdata_i
//
// One slot is examined per cycle through the slot memory read port; a join then
// passes through the multiply state and the divider before its result.
// Reset clears the slot valid bits at once; no clearing pass is needed.
// busy_o is high from acceptance until the result strobe; results cannot stall.
// With no slots in use busy_o stays low and the drop result follows in the
// cycle after acceptance.
module blob_cluster_accumulator import bca_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  pixel_t                   pixel_i,
  output logic                     busy_o,
  output logic                     valid_o,
  output result_t                  result_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [RADIUS_BITS-1:0] radius_q;
  logic [SIU_BITS-1:0]    slots_in_use_q;
  logic [MEAN_BITS-1:0]   prow_q, pcol_q;
  logic [SCAN_BITS-1:0]   limit_q, chk_q, chk_d, chk_nxt, limit_new;
  slot_entry_t            hit_q;

  slot_entry_t            mem_q [SLOTS];
  logic [SLOTS-1:0]       slot_vld_q;
  slot_entry_t            rd_entry_q;
  logic                   rd_vld_q;
  logic [SLOT_BITS-1:0]   rd_addr, wr_addr;
  logic                   wr_en;
  slot_entry_t            wr_data;

  logic                   valid_d, valid_q;
  result_t                result_d, result_q;
  logic                   accept, load_hit, load_item;

  logic [MEAN_BITS-1:0]   radius_fx, diff_row, diff_col;
  logic                   match;
  logic [COUNT_BITS-1:0]  new_count;

  div_req_t               div_req;
  logic                   div_start, div_done;
  logic [MEAN_BITS-1:0]   quot_row, quot_col;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign chk_nxt = chk_q + SCAN_BITS'(1);

  assign limit_new = (SCAN_BITS'(slots_in_use_q) > SCAN_BITS'(SLOTS)) ?
                     SCAN_BITS'(SLOTS) : SCAN_BITS'(slots_in_use_q);

  assign radius_fx = {radius_q, {FRAC_BITS{1'b0}}};
  assign diff_row  = (prow_q > rd_entry_q.row_mean) ? prow_q - rd_entry_q.row_mean
                                                     : rd_entry_q.row_mean - prow_q;
  assign diff_col  = (pcol_q > rd_entry_q.col_mean) ? pcol_q - rd_entry_q.col_mean
                                                     : rd_entry_q.col_mean - pcol_q;
  assign match     = (diff_row < radius_fx) && (diff_col < radius_fx);

  assign new_count = (hit_q.count == COUNT_MAX) ? hit_q.count
                                                : hit_q.count + COUNT_BITS'(1);

  assign div_req.dividend_row = DIVIDEND_BITS'(hit_q.row_mean) * DIVIDEND_BITS'(hit_q.count)
                              + DIVIDEND_BITS'(prow_q);
  assign div_req.dividend_col = DIVIDEND_BITS'(hit_q.col_mean) * DIVIDEND_BITS'(hit_q.count)
                              + DIVIDEND_BITS'(pcol_q);
  assign div_req.divisor      = DIVISOR_BITS'(hit_q.count) + DIVISOR_BITS'(1);
  assign div_start            = (state_q == ST_MUL);

  bca_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .req_i      (div_req),
    .done_o     (div_done),
    .quot_row_o (quot_row),
    .quot_col_o (quot_col)
  );

  always_comb begin
    state_d   = state_q;
    chk_d     = chk_q;
    valid_d   = 1'b0;
    result_d  = result_q;
    wr_en     = 1'b0;
    wr_addr   = chk_q[SLOT_BITS-1:0];
    wr_data   = hit_q;
    load_hit  = 1'b0;
    load_item = 1'b0;
    rd_addr   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load_item = 1'b0;
          chk_d     = '0;
          if (limit_new == '0) begin
            valid_d  = 1'b1;
            result_d = '{outcome: OUT_DROP, default: '0};
          end else begin
            load_item = 1'b1;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_addr = chk_nxt[SLOT_BITS-1:0];
        priority if (!rd_vld_q) begin
          wr_en    = 1'b1;
          wr_data  = '{count: COUNT_BITS'(1), row_mean: prow_q, col_mean: pcol_q};
          valid_d  = 1'b1;
          result_d = '{outcome: OUT_NEW, slot_index: SLOT_IDX_BITS'(chk_q),
                       mean_row: OUT_MEAN_BITS'(prow_q), mean_col: OUT_MEAN_BITS'(pcol_q),
                       member_count: OUT_CNT_BITS'(1)};
          state_d  = ST_IDLE;
        end else if (match) begin
          load_hit = 1'b1;
          state_d  = ST_MUL;
        end else if (chk_nxt >= limit_q) begin
          valid_d  = 1'b1;
          result_d = '{outcome: OUT_DROP, default: '0};
          state_d  = ST_IDLE;
        end else begin
          chk_d = chk_nxt;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          wr_en    = 1'b1;
          wr_data  = '{count: new_count, row_mean: quot_row, col_mean: quot_col};
          valid_d  = 1'b1;
          result_d = '{outcome: OUT_JOIN, slot_index: SLOT_IDX_BITS'(chk_q),
                       mean_row: OUT_MEAN_BITS'(quot_row), mean_col: OUT_MEAN_BITS'(quot_col),
                       member_count: OUT_CNT_BITS'(new_count)};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= 1'b0;
      slot_vld_q <= '0;
      chk_q      <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      chk_q   <= chk_d;
      if (wr_en) begin
        slot_vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q       <= RADIUS_RESET;
      slots_in_use_q <= SLOTS_IN_USE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MATCH_RADIUS: radius_q       <= cfg_wdata_i[RADIUS_BITS-1:0];
        CFG_SLOTS_IN_USE: slots_in_use_q <= cfg_wdata_i[SIU_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      prow_q  <= {pixel_i.pixel_row, {FRAC_BITS{1'b0}}};
      pcol_q  <= {pixel_i.pixel_col, {FRAC_BITS{1'b0}}};
      limit_q <= limit_new;
    end
    if (load_hit) begin
      hit_q <= rd_entry_q;
    end
    result_q <= result_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_entry_q <= mem_q[rd_addr];
    rd_vld_q   <= slot_vld_q[rd_addr];
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- sv/bca_checker.sv -----
// Port-level checker for the blob cluster accumulator, with its bind.
// Depends on bca_pkg and blob_cluster_accumulator_assert.svh.
`include "blob_cluster_accumulator_assert.svh"

module bca_port_checker import bca_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input logic    busy_o,
  input logic    valid_o,
  input result_t result_o
);

  // A result is strobed whenever busy drops.
  `BCA_ASSERT_IMPL(a_fell_busy_gives_result, clk_i, rst_ni, $fell(busy_o), valid_o)

  `BCA_ASSERT_IMPL(a_result_not_busy, clk_i, rst_ni, valid_o, !busy_o)

  `BCA_ASSERT_IMPL(a_drop_is_zero, clk_i, rst_ni,
                   valid_o && (result_o.outcome == OUT_DROP),
                   (result_o.slot_index == '0) && (result_o.member_count == '0))

  `BCA_ASSERT_IMPL(a_new_count_one, clk_i, rst_ni,
                   valid_o && (result_o.outcome == OUT_NEW),
                   result_o.member_count == OUT_CNT_BITS'(1))

  `BCA_ASSERT_NEXT(a_accept_answered, clk_i, rst_ni,
                   start_i && !busy_o, busy_o || valid_o)

endmodule

bind blob_cluster_accumulator bca_port_checker u_bca_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .valid_o  (valid_o),
  .result_o (result_o)
);

// ----- dv/bca_checker.sv -----
// Checker for the blob cluster accumulator: keeps its own blob table, predicts
// the result of every accepted transaction and compares it with the strobed result.
// Depends on bca_pkg.
`timescale 1ns / 1ps

module bca_checker import bca_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  pixel_t                   pixel_i,
  input  logic                     valid_i,
  input  result_t                  result_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output int                       mismatches_o,
  output int                       pending_o
);

  localparam int REPORT_LIMIT = 100;

  logic [COUNT_BITS-1:0] blob_count    [SLOTS];
  logic [MEAN_BITS-1:0]  blob_row_mean [SLOTS];
  logic [MEAN_BITS-1:0]  blob_col_mean [SLOTS];
  logic [RADIUS_BITS-1:0] radius_q;
  logic [SIU_BITS-1:0]    scan_slots_q;
  result_t predicted_updates[$];
  result_t want;

  task automatic report_mismatch(string msg);
    if (mismatches_o < REPORT_LIMIT) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatches_o++;
  endtask

  function automatic logic [MEAN_BITS-1:0] axis_gap(logic [MEAN_BITS-1:0] a,
                                                   logic [MEAN_BITS-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [MEAN_BITS-1:0] running_mean(logic [MEAN_BITS-1:0]  mean,
                                                       logic [COUNT_BITS-1:0] weight,
                                                       logic [MEAN_BITS-1:0]  point);
    logic [DIVIDEND_BITS-1:0] total;
    total = DIVIDEND_BITS'(mean) * DIVIDEND_BITS'(weight) + DIVIDEND_BITS'(point);
    return MEAN_BITS'(total / (DIVIDEND_BITS'(weight) + DIVIDEND_BITS'(1)));
  endfunction

  // The scan stops at the first empty slot or the first blob within reach on both axes.
  function automatic result_t cluster_point(pixel_t px);
    logic [MEAN_BITS-1:0] prow;
    logic [MEAN_BITS-1:0] pcol;
    logic [MEAN_BITS-1:0] reach;
    int                   limit;
    result_t              res;
    prow  = MEAN_BITS'(px.pixel_row) << FRAC_BITS;
    pcol  = MEAN_BITS'(px.pixel_col) << FRAC_BITS;
    reach = MEAN_BITS'(radius_q) << FRAC_BITS;
    limit = (int'(scan_slots_q) > SLOTS) ? SLOTS : int'(scan_slots_q);
    res = '0;
    res.outcome = OUT_DROP;
    for (int i = 0; i < limit; i++) begin
      if (blob_count[i] == '0) begin
        blob_row_mean[i] = prow;
        blob_col_mean[i] = pcol;
        blob_count[i]    = COUNT_BITS'(1);
        res.outcome      = OUT_NEW;
      end else if (axis_gap(prow, blob_row_mean[i]) < reach &&
                   axis_gap(pcol, blob_col_mean[i]) < reach) begin
        blob_row_mean[i] = running_mean(blob_row_mean[i], blob_count[i], prow);
        blob_col_mean[i] = running_mean(blob_col_mean[i], blob_count[i], pcol);
        if (blob_count[i] != COUNT_MAX) begin
          blob_count[i] = blob_count[i] + COUNT_BITS'(1);
        end
        res.outcome = OUT_JOIN;
      end
      if (res.outcome != OUT_DROP) begin
        res.slot_index   = SLOT_IDX_BITS'(i);
        res.mean_row     = OUT_MEAN_BITS'(blob_row_mean[i]);
        res.mean_col     = OUT_MEAN_BITS'(blob_col_mean[i]);
        res.member_count = OUT_CNT_BITS'(blob_count[i]);
        break;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        blob_count[i]    = '0;
        blob_row_mean[i] = '0;
        blob_col_mean[i] = '0;
      end
      radius_q     = RADIUS_RESET;
      scan_slots_q = SLOTS_IN_USE_RESET;
      predicted_updates.delete();
      mismatches_o = 0;
      pending_o   <= 0;
    end else begin
      if (valid_i) begin
        if (predicted_updates.size() == 0) begin
          report_mismatch($sformatf("result %h with no transaction pending", result_i));
        end else begin
          want = predicted_updates.pop_front();
          if (result_i.outcome !== want.outcome) begin
            report_mismatch($sformatf("outcome %0d, expected %0d",
                                      result_i.outcome, want.outcome));
          end
          if (result_i.slot_index !== want.slot_index) begin
            report_mismatch($sformatf("slot_index %0d, expected %0d",
                                      result_i.slot_index, want.slot_index));
          end
          if (result_i.mean_row !== want.mean_row) begin
            report_mismatch($sformatf("mean_row %h, expected %h",
                                      result_i.mean_row, want.mean_row));
          end
          if (result_i.mean_col !== want.mean_col) begin
            report_mismatch($sformatf("mean_col %h, expected %h",
                                      result_i.mean_col, want.mean_col));
          end
          if (result_i.member_count !== want.member_count) begin
            report_mismatch($sformatf("member_count %0d, expected %0d",
                                      result_i.member_count, want.member_count));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MATCH_RADIUS: radius_q     = cfg_wdata_i[RADIUS_BITS-1:0];
          CFG_SLOTS_IN_USE: scan_slots_q = cfg_wdata_i[SIU_BITS-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        predicted_updates.push_back(cluster_point(pixel_i));
      end
      pending_o <= predicted_updates.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the blob cluster accumulator: drives pixel transactions and
// register writes, and gives the verdict from the count kept by bca_checker.
// Depends on bca_pkg, bca_checker and blob_cluster_accumulator.
`timescale 1ns / 1ps

module tb;
  import bca_pkg::*;

  localparam int COORD_MAX    = 2**COORD_BITS - 1;
  localparam int DATA_MAX     = 2**CFG_DATA_BITS - 1;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 123;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start_i;
  pixel_t                   pixel_i;
  logic                     busy_o;
  logic                     valid_o;
  result_t                  result_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;

  int          mismatches;
  int          pending;
  int unsigned quiet_cycles = 0;
  int          phase_radius = 0;
  bit          steady = 1'b0;
  pixel_t      sent_pixels[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  blob_cluster_accumulator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .pixel_i    (pixel_i),
    .busy_o     (busy_o),
    .valid_o    (valid_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  bca_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .pixel_i     (pixel_i),
    .valid_i     (valid_o),
    .result_i    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_BITS-1:0] jitter(logic [COORD_BITS-1:0] c, int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_BITS'(v);
  endfunction

  // Most random points land near an earlier point so that they join its blob.
  function automatic pixel_t near_pixel();
    pixel_t anchor;
    pixel_t px;
    int     span;
    anchor = sent_pixels[$urandom_range(0, sent_pixels.size() - 1)];
    span = (phase_radius > 40) ? 40 : phase_radius;
    px.pixel_row = jitter(anchor.pixel_row, span);
    px.pixel_col = jitter(anchor.pixel_col, span);
    return px;
  endfunction

  task automatic send_pixel(int row, int col);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i           <= 1'b1;
    pixel_i.pixel_row <= COORD_BITS'(row);
    pixel_i.pixel_col <= COORD_BITS'(col);
    do @(posedge clk_i); while (busy_o);
    sent_pixels.push_back({COORD_BITS'(row), COORD_BITS'(col)});
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy_o);
  endtask

  task automatic configure(int radius, int scan);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MATCH_RADIUS;
    cfg_wdata_i <= CFG_DATA_BITS'(radius);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SLOTS_IN_USE;
    cfg_wdata_i <= CFG_DATA_BITS'(scan);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    phase_radius = radius & COORD_MAX;
  endtask

  initial begin
    int     radius;
    int     scan;
    pixel_t px;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    pixel_i     <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_MATCH_RADIUS;
    cfg_wdata_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With a zero radius identical points still open separate blobs; the fourth is dropped.
    configure(0, 3);
    send_pixel(0, 0);
    send_pixel(0, 0);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel(5, 5);
    // A scan width whose low byte is zero examines no slot at all.
    configure(COORD_MAX, 256);
    send_pixel(1024, 1024);
    configure(COORD_MAX, 1);
    send_pixel(COORD_MAX, 0);
    send_pixel(1024, 1024);
    send_pixel(COORD_MAX - 1, COORD_MAX - 1);
    send_pixel(0, COORD_MAX);
    // A scan width above the table size is limited to the table.
    configure(1, 255);
    send_pixel(0, 0);
    send_pixel(0, 1);
    send_pixel(1, 0);
    send_pixel(1365, 682);
    send_pixel(1365, 682);
    send_pixel(682, 1365);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       radius = 64;
        1:       radius = 1;
        2:       radius = COORD_MAX;
        3:       radius = 0;
        default: radius = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 100)
                                                      : $urandom_range(1, COORD_MAX);
      endcase
      case (ph)
        1:       scan = 255;
        3:       scan = 200;
        4:       scan = $urandom_range(0, DATA_MAX);
        6:       scan = $urandom_range(1, 20);
        default: scan = SLOTS;
      endcase
      configure(radius, scan);
      steady = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          px = near_pixel();
        end else begin
          px = pixel_t'($urandom_range(0, 2**(2 * COORD_BITS) - 1));
        end
        send_pixel(px.pixel_row, px.pixel_col);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/bca_pkg.sv
sv/bca_divider.sv
sv/blob_cluster_accumulator.sv
sv/bca_checker.sv
dv/bca_checker.sv
dv/tb.sv
